/* rtl/core/zhs_pkg.sv */
// shared types and constants for the zip local header scanner
package zhs_pkg;

  // one input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } zhs_in_t;

  // one result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] name_char;
    logic       name_last;
    logic       sig_found;
  } zhs_out_t;

  // results produced by one input item, first one goes out first
  typedef struct packed {
    logic [1:0] count;
    zhs_out_t   first;
    zhs_out_t   second;
  } zhs_res_t;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_EOS   = 2'd2;

  localparam logic [23:0] SIG_HEAD = 24'h504B03;
  localparam logic [7:0]  SIG_LAST = 8'h04;

  localparam logic [4:0] HDR_FIRST_POS = 5'd4;
  localparam logic [4:0] HDR_LAST_POS  = 5'd29;
  localparam logic [4:0] POS_SIZE0     = 5'd18;
  localparam logic [4:0] POS_SIZE1     = 5'd19;
  localparam logic [4:0] POS_SIZE2     = 5'd20;
  localparam logic [4:0] POS_SIZE3     = 5'd21;
  localparam logic [4:0] POS_NAME0     = 5'd26;
  localparam logic [4:0] POS_NAME1     = 5'd27;
  localparam logic [4:0] POS_EXTRA0    = 5'd28;
  localparam logic [4:0] POS_EXTRA1    = 5'd29;

endpackage

/* rtl/core/zhs_parser.sv */
// header parser: scan state and per-byte result generation
module zhs_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  zhs_pkg::zhs_in_t item_i,
  output zhs_pkg::zhs_res_t res_o
);
  import zhs_pkg::*;

  typedef enum logic [1:0] {
    PH_SCAN   = 2'd0,
    PH_HEADER = 2'd1,
    PH_NAME   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [23:0] window_q, window_d;
  logic [1:0]  fill_q, fill_d;
  logic [4:0]  hpos_q, hpos_d;
  logic [31:0] size_q, size_d;
  logic [15:0] name_len_q, name_len_d;
  logic [15:0] extra_len_q, extra_len_d;
  logic [32:0] remain_q, remain_d;
  logic        seen_q, seen_d;

  logic [7:0]  b;
  logic        eos;
  logic [32:0] skip_len;
  logic        skip_now;
  zhs_out_t    name_res;
  zhs_out_t    eos_res;
  logic        name_hit;

  assign b   = item_i.data_byte;
  assign eos = item_i.end_of_stream;

  always_comb begin
    phase_d     = phase_q;
    window_d    = window_q;
    fill_d      = fill_q;
    hpos_d      = hpos_q;
    size_d      = size_q;
    name_len_d  = name_len_q;
    extra_len_d = extra_len_q;
    remain_d    = remain_q;
    seen_d      = seen_q;
    name_hit    = 1'b0;
    name_res    = '0;
    skip_len    = '0;
    skip_now    = 1'b0;

    unique case (phase_q)
      PH_SCAN: begin
        if (fill_q == 2'd3 && window_q == SIG_HEAD && b == SIG_LAST) begin
          seen_d      = 1'b1;
          phase_d     = PH_HEADER;
          hpos_d      = HDR_FIRST_POS;
          size_d      = '0;
          name_len_d  = '0;
          extra_len_d = '0;
        end else begin
          window_d = {window_q[15:0], b};
          if (fill_q != 2'd3) begin
            fill_d = fill_q + 2'd1;
          end
        end
      end
      PH_HEADER: begin
        unique case (hpos_q)
          POS_SIZE0:  size_d[7:0]       = size_q[7:0] | b;
          POS_SIZE1:  size_d[15:8]      = size_q[15:8] | b;
          POS_SIZE2:  size_d[23:16]     = size_q[23:16] | b;
          POS_SIZE3:  size_d[31:24]     = size_q[31:24] | b;
          POS_NAME0:  name_len_d[7:0]   = name_len_q[7:0] | b;
          POS_NAME1:  name_len_d[15:8]  = name_len_q[15:8] | b;
          POS_EXTRA0: extra_len_d[7:0]  = extra_len_q[7:0] | b;
          POS_EXTRA1: extra_len_d[15:8] = extra_len_q[15:8] | b;
          default: ;
        endcase
        if (hpos_q == HDR_LAST_POS) begin
          hpos_d = '0;
          if (name_len_q == '0) begin
            name_hit           = 1'b1;
            name_res.kind      = KIND_EMPTY;
            name_res.name_last = 1'b1;
            skip_now           = 1'b1;
            skip_len           = {1'b0, size_d} + {17'd0, extra_len_d};
          end else begin
            phase_d  = PH_NAME;
            remain_d = {17'd0, name_len_q};
          end
        end else begin
          hpos_d = hpos_q + 5'd1;
        end
      end
      PH_NAME: begin
        name_hit           = 1'b1;
        name_res.kind      = KIND_NAME;
        name_res.name_char = b;
        name_res.name_last = (remain_q <= 33'd1) || eos;
        if (remain_q <= 33'd1) begin
          skip_now = 1'b1;
          skip_len = {1'b0, size_q} + {17'd0, extra_len_q};
        end else begin
          remain_d = remain_q - 33'd1;
        end
      end
      PH_SKIP: begin
        if (remain_q <= 33'd1) begin
          phase_d  = PH_SCAN;
          window_d = '0;
          fill_d   = '0;
        end else begin
          remain_d = remain_q - 33'd1;
        end
      end
      default: ;
    endcase

    // nothing to skip goes straight back to scanning with a clear window
    if (skip_now) begin
      remain_d = skip_len;
      if (skip_len == '0) begin
        phase_d  = PH_SCAN;
        window_d = '0;
        fill_d   = '0;
      end else begin
        phase_d = PH_SKIP;
      end
    end

    eos_res           = '0;
    eos_res.kind      = KIND_EOS;
    eos_res.sig_found = seen_d;

    res_o = '0;
    if (name_hit) begin
      res_o.first = name_res;
      if (eos) begin
        res_o.second = eos_res;
        res_o.count  = 2'd2;
      end else begin
        res_o.count = 2'd1;
      end
    end else if (eos) begin
      res_o.first = eos_res;
      res_o.count = 2'd1;
    end

    // end of stream returns everything to reset
    if (eos) begin
      phase_d     = PH_SCAN;
      window_d    = '0;
      fill_d      = '0;
      hpos_d      = '0;
      size_d      = '0;
      name_len_d  = '0;
      extra_len_d = '0;
      remain_d    = '0;
      seen_d      = 1'b0;
    end

    if (!step_i) begin
      res_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SCAN;
      window_q    <= '0;
      fill_q      <= '0;
      hpos_q      <= '0;
      size_q      <= '0;
      name_len_q  <= '0;
      extra_len_q <= '0;
      remain_q    <= '0;
      seen_q      <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      window_q    <= window_d;
      fill_q      <= fill_d;
      hpos_q      <= hpos_d;
      size_q      <= size_d;
      name_len_q  <= name_len_d;
      extra_len_q <= extra_len_d;
      remain_q    <= remain_d;
      seen_q      <= seen_d;
    end
  end

endmodule

/* rtl/core/zhs_res_fifo.sv */
// four-entry result queue, takes up to two results per cycle
module zhs_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  zhs_pkg::zhs_res_t res_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output zhs_pkg::zhs_out_t out_data_o
);
  import zhs_pkg::*;

  zhs_out_t   mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for two more beats whatever the output side does
  assign space_o     = (cnt_q <= 3'd2);

  assign wr_d  = wr_q + res_i.count;
  assign rd_d  = rd_q + {1'b0, pop};
  assign cnt_d = cnt_q + {1'b0, res_i.count} - {2'b0, pop};

  always_ff @(posedge clk_i) begin
    if (res_i.count != 2'd0) begin
      mem_q[wr_q] <= res_i.first;
    end
    if (res_i.count == 2'd2) begin
      mem_q[wr_q + 2'd1] <= res_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/core/zip_local_header_scanner.sv */
// zip local header scanner top level
//
//   channel  direction  payload              handshake
//   in       input      zhs_in_t  (1 byte)   in_valid_i / in_ready_o
//   out      output     zhs_out_t (1 result) out_valid_o / out_ready_i
//
// one byte per cycle while the queue has room: each byte waits in the input register,
// the parser updates its state and pushes zero, one or two results into a 4-entry
// queue. the first result is valid on out once it is written into the queue.
// the input register holds while the queue has fewer than two free entries.
// reset clears all scan state; the stream starts in scanning with an empty window.
module zip_local_header_scanner (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  zhs_pkg::zhs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output zhs_pkg::zhs_out_t out_data_o
);
  import zhs_pkg::*;

  zhs_in_t  stage_q;
  logic     stage_v_q, stage_v_d;
  logic     space;
  logic     advance;
  logic     in_take;
  zhs_res_t res;

  assign advance    = stage_v_q && space;
  assign in_ready_o = !stage_v_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    stage_v_d = stage_v_q;
    if (in_take) begin
      stage_v_d = 1'b1;
    end else if (advance) begin
      stage_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stage_q <= in_data_i;
    end
  end

  zhs_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (stage_q),
    .res_o  (res)
  );

  zhs_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/core/zhs_checker.sv */
// port-level checks for the zip local header scanner
module zhs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input zhs_pkg::zhs_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input zhs_pkg::zhs_out_t out_data_o
);
  import zhs_pkg::*;

  // an offered byte beat holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("byte beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kind == KIND_NAME || out_data_o.kind == KIND_EMPTY
                     || out_data_o.kind == KIND_EOS))
    else $error("result kind out of range");

  // name results never carry the found flag
  a_name_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_NAME || out_data_o.kind == KIND_EMPTY)
      |-> !out_data_o.sig_found)
    else $error("found flag on a name result");

  // empty name and report carry no character; report never marks last
  a_empty_eos_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_EMPTY || out_data_o.kind == KIND_EOS)
      |-> out_data_o.name_char == 8'd0
          && out_data_o.name_last == (out_data_o.kind == KIND_EMPTY))
    else $error("bad fields on empty-name or report beat");

endmodule

bind zip_local_header_scanner zhs_checker u_zhs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* sim/zhs_checker.sv */
// beat monitor, scan predictor and result comparison for the zip local header scanner
`timescale 1ns / 100ps

module zhs_scoreboard
  import zhs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  zhs_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  zhs_out_t out_data_i,
  output int       fail_count_o,
  output int       awaited_o
);

  typedef enum logic [1:0] {
    SCANNING  = 2'd0,
    IN_HEADER = 2'd1,
    IN_NAME   = 2'd2,
    SKIPPING  = 2'd3
  } scan_phase_e;

  // predicted scanner state
  logic [23:0] window;
  logic [1:0]  window_fill;
  scan_phase_e phase;
  logic [4:0]  hdr_pos;
  logic [31:0] comp_size;
  logic [15:0] name_len;
  logic [15:0] extra_len;
  logic [32:0] left;
  logic        sig_seen;

  zhs_out_t awaited_results[$];
  int       errors = 0;

  function automatic zhs_out_t make_result(logic [1:0] kind, logic [7:0] ch, logic last,
                                           logic found);
    zhs_out_t r;
    r.kind      = kind;
    r.name_char = ch;
    r.name_last = last;
    r.sig_found = found;
    return r;
  endfunction

  task automatic clear_scan_state();
    window      = '0;
    window_fill = '0;
    phase       = SCANNING;
    hdr_pos     = '0;
    comp_size   = '0;
    name_len    = '0;
    extra_len   = '0;
    left        = '0;
    sig_seen    = 1'b0;
  endtask

  task automatic resume_scanning();
    phase       = SCANNING;
    window      = '0;
    window_fill = '0;
  endtask

  task automatic start_skip();
    left = {17'd0, extra_len} + {1'b0, comp_size};
    if (left == '0) begin
      resume_scanning();
    end else begin
      phase = SKIPPING;
    end
  endtask

  task automatic scan_byte(input zhs_in_t beat);
    logic [7:0] b;
    logic       eos;
    b   = beat.data_byte;
    eos = beat.end_of_stream;
    case (phase)
      SCANNING: begin
        if (window_fill == 2'd3 && window == SIG_HEAD && b == SIG_LAST) begin
          sig_seen  = 1'b1;
          phase     = IN_HEADER;
          hdr_pos   = HDR_FIRST_POS;
          comp_size = '0;
          name_len  = '0;
          extra_len = '0;
        end else begin
          window = {window[15:0], b};
          if (window_fill != 2'd3) window_fill = window_fill + 2'd1;
        end
      end
      IN_HEADER: begin
        case (hdr_pos)
          POS_SIZE0:  comp_size[7:0]   = b;
          POS_SIZE1:  comp_size[15:8]  = b;
          POS_SIZE2:  comp_size[23:16] = b;
          POS_SIZE3:  comp_size[31:24] = b;
          POS_NAME0:  name_len[7:0]    = b;
          POS_NAME1:  name_len[15:8]   = b;
          POS_EXTRA0: extra_len[7:0]   = b;
          POS_EXTRA1: extra_len[15:8]  = b;
          default: ;
        endcase
        if (hdr_pos == HDR_LAST_POS) begin
          hdr_pos = '0;
          if (name_len == '0) begin
            awaited_results.push_back(make_result(KIND_EMPTY, 8'h00, 1'b1, 1'b0));
            start_skip();
          end else begin
            phase = IN_NAME;
            left  = {17'd0, name_len};
          end
        end else begin
          hdr_pos = hdr_pos + 5'd1;
        end
      end
      IN_NAME: begin
        awaited_results.push_back(make_result(KIND_NAME, b, (left <= 33'd1) || eos, 1'b0));
        if (left <= 33'd1) begin
          start_skip();
        end else begin
          left = left - 33'd1;
        end
      end
      default: begin
        if (left <= 33'd1) begin
          resume_scanning();
        end else begin
          left = left - 33'd1;
        end
      end
    endcase
    // the end-of-stream report always follows whatever the byte produced
    if (eos) begin
      awaited_results.push_back(make_result(KIND_EOS, 8'h00, 1'b0, sig_seen));
      clear_scan_state();
    end
  endtask

  task automatic check_result(input zhs_out_t got);
    zhs_out_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result beat kind=%0d char=%h last=%b found=%b",
               $time, got.kind, got.name_char, got.name_last, got.sig_found);
      errors++;
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) begin
        errors++;
        if (got.kind !== want.kind)
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        if (got.name_char !== want.name_char)
          $display("%0t: name_char expected %h actual %h", $time, want.name_char,
                   got.name_char);
        if (got.name_last !== want.name_last)
          $display("%0t: name_last expected %b actual %b", $time, want.name_last,
                   got.name_last);
        if (got.sig_found !== want.sig_found)
          $display("%0t: sig_found expected %b actual %b", $time, want.sig_found,
                   got.sig_found);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan_state();
      awaited_results.delete();
      fail_count_o <= 0;
      awaited_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) scan_byte(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      awaited_o    <= awaited_results.size();
      fail_count_o <= errors;
    end
  end

endmodule

/* sim/zip_local_header_scanner_test.sv */
// stimulus, ready pattern, watchdog and verdict for the zip local header scanner
`timescale 1ns / 100ps

module zip_local_header_scanner_test;
  import zhs_pkg::*;

  localparam int ITEMS          = 1850;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF       = 400;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  zhs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  zhs_out_t out_data;

  int fail_count;
  int awaited;
  int items_sent  = 0;
  int idle_cycles = 0;

  logic [7:0] stream_q[$];

  always #10 clk = ~clk;

  zip_local_header_scanner dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  zhs_scoreboard u_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .awaited_o   (awaited)
  );

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // biased toward signature bytes so partial and overlapping matches show up
  function automatic logic [7:0] junk_byte();
    case ($urandom_range(0, 7))
      0: return SIG_HEAD[23:16];
      1: return SIG_HEAD[15:8];
      2: return SIG_HEAD[7:0];
      3: return SIG_LAST;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input bit burst);
    int      gap;
    zhs_in_t beat;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.data_byte     = b;
    beat.end_of_stream = eos;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_stream();
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1, burst);
    stream_q.delete();
  endtask

  task automatic add_random_bytes(input longint n);
    for (longint i = 0; i < n; i++) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_header(input logic [15:0] nlen, input logic [15:0] xlen,
                            input logic [31:0] dsize);
    logic [7:0] b;
    stream_q.push_back(SIG_HEAD[23:16]);
    stream_q.push_back(SIG_HEAD[15:8]);
    stream_q.push_back(SIG_HEAD[7:0]);
    stream_q.push_back(SIG_LAST);
    for (int p = HDR_FIRST_POS; p <= HDR_LAST_POS; p++) begin
      case (p)
        POS_SIZE0:  b = dsize[7:0];
        POS_SIZE1:  b = dsize[15:8];
        POS_SIZE2:  b = dsize[23:16];
        POS_SIZE3:  b = dsize[31:24];
        POS_NAME0:  b = nlen[7:0];
        POS_NAME1:  b = nlen[15:8];
        POS_EXTRA0: b = xlen[7:0];
        POS_EXTRA1: b = xlen[15:8];
        default:    b = 8'($urandom_range(0, 255));
      endcase
      stream_q.push_back(b);
    end
  endtask

  // one or more local entries; huge lengths end the stream partway through
  task automatic build_archive(input bit broken);
    int          files;
    int          keep;
    logic [15:0] nlen;
    logic [15:0] xlen;
    logic [31:0] dsize;
    longint      skip_len;
    bit          cut;
    cut = 1'b0;
    repeat ($urandom_range(0, 4)) stream_q.push_back(junk_byte());
    files = $urandom_range(1, 3);
    for (int f = 0; f < files && !cut; f++) begin
      case ($urandom_range(0, 9))
        0:       nlen = 16'd0;
        1:       nlen = 16'($urandom_range(0, 65535));
        default: nlen = 16'($urandom_range(1, 6));
      endcase
      xlen  = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 4));
      dsize = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 12);
      add_header(nlen, xlen, dsize);
      skip_len = longint'(xlen) + longint'(dsize);
      if (nlen > 16'd40) begin
        add_random_bytes(longint'($urandom_range(1, 40)));
        cut = 1'b1;
      end else begin
        add_random_bytes(longint'(nlen));
        if (skip_len > 64) begin
          add_random_bytes(longint'($urandom_range(0, 30)));
          cut = 1'b1;
        end else begin
          add_random_bytes(skip_len);
          repeat ($urandom_range(0, 2)) stream_q.push_back(junk_byte());
        end
      end
    end
    if (broken) begin
      keep     = $urandom_range(1, stream_q.size());
      stream_q = stream_q[0:keep-1];
    end
  endtask

  // receiver: random ready runs, one long hold-off to back the block up
  initial begin
    int  round;
    int  r;
    int  n;
    bit  v;
    round = 0;
    forever begin
      round++;
      r = $urandom_range(0, 99);
      if (round == 60) begin
        v = 1'b0;
        n = HOLD_OFF;
      end else if (r < 5) begin
        v = 1'b1;
        n = $urandom_range(100, 200);
      end else if (r < 60) begin
        v = 1'b1;
        n = $urandom_range(1, 20);
      end else if (r < 92) begin
        v = 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        v = 1'b0;
        n = $urandom_range(8, 40);
      end
      out_ready <= v;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (!in_valid && awaited == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone end-of-stream byte, nothing found
    stream_q.push_back(8'hFF);
    send_stream();
    // empty name, nothing to skip, then scanning resumes on the very next byte
    add_header(16'd0, 16'd0, 32'd0);
    stream_q.push_back(8'h00);
    send_stream();

    while (items_sent < ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        repeat ($urandom_range(1, 24)) stream_q.push_back(junk_byte());
      end else begin
        build_archive(mode == 2);
      end
      send_stream();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/zhs_pkg.sv
rtl/core/zhs_parser.sv
rtl/core/zhs_res_fifo.sv
rtl/core/zip_local_header_scanner.sv
rtl/core/zhs_checker.sv
sim/zhs_checker.sv
sim/zip_local_header_scanner_test.sv
